// File: design/ira_pkg.sv
// Shared types, constants and helper functions for the integer to radix ASCII converter.
`timescale 1ns / 1ps
`default_nettype none

package ira_pkg;

   localparam int DEFAULT_VALUE_WIDTH = 32;
   localparam int RADIX_W             = 5;
   localparam int DIGIT_W             = 4;
   localparam int CHAR_W              = 8;
   localparam int STEP_BITS           = 8;
   localparam int QUEUE_DEPTH         = 2;
   localparam int CSR_ADDR_W          = 3;
   localparam int CSR_DATA_W          = 32;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd16;

   // Word index of the radix register within the configuration space.
   localparam logic CSR_RADIX_WORD = 1'b0;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   typedef struct packed {
      logic               neg;
      logic [RADIX_W-1:0] radix;
      logic               pow2;
      logic [2:0]         shift;
   } ira_class_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } ira_state_type;

   function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      begin
         res = r;
         if (r < RADIX_MIN) begin
            res = RADIX_MIN;
         end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
         end
         return res;
      end
   endfunction

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] res;
      begin
         if (d <= 4'd9) begin
            res = CHAR_ZERO + CHAR_W'(d);
         end else begin
            res = CHAR_A + CHAR_W'(d) - 8'd10;
         end
         return res;
      end
   endfunction

endpackage

`default_nettype wire

// File: design/ira_front.sv
// Front end: accepts integers, forms sign and magnitude and classifies the radix.
`timescale 1ns / 1ps
`default_nettype none

module ira_front #(
   parameter int VALUE_WIDTH = ira_pkg::DEFAULT_VALUE_WIDTH
) (
   input  wire logic                              req_valid,
   input  wire logic signed [VALUE_WIDTH-1:0]     req_value,
   output logic                                   req_stall,
   input  wire logic [ira_pkg::RADIX_W-1:0]       radix,
   input  wire logic                              queue_full,
   output logic                                   push,
   output ira_pkg::ira_class_type                 push_class,
   output logic [VALUE_WIDTH-1:0]                 push_mag
);

   logic [ira_pkg::RADIX_W-1:0] radix_eff;
   logic [VALUE_WIDTH-1:0]      raw;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign raw       = req_value;
   assign radix_eff = ira_pkg::effective_radix(radix);

   always_comb begin
      push_class.neg   = raw[VALUE_WIDTH-1];
      push_class.radix = radix_eff;
      push_class.pow2  = 1'b1;
      push_class.shift = 3'd4;
      unique case (radix_eff)
         5'd2:    push_class.shift = 3'd1;
         5'd4:    push_class.shift = 3'd2;
         5'd8:    push_class.shift = 3'd3;
         5'd16:   push_class.shift = 3'd4;
         default: begin
            push_class.pow2  = 1'b0;
            push_class.shift = 3'd0;
         end
      endcase
   end

   // The most negative value negates to itself, which read unsigned is its magnitude.
   assign push_mag = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;

endmodule

`default_nettype wire

// File: design/ira_queue.sv
// Short first-in first-out queue between the front end and the conversion engine.
`timescale 1ns / 1ps
`default_nettype none

module ira_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int DEPTH   = ira_pkg::QUEUE_DEPTH;
   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]   entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == COUNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: design/ira_back.sv
// Conversion engine: iterative digit division, digit stack and character output register.
`timescale 1ns / 1ps
`default_nettype none

module ira_back #(
   parameter int VALUE_WIDTH = ira_pkg::DEFAULT_VALUE_WIDTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             queue_empty,
   input  wire ira_pkg::ira_class_type           queue_class,
   input  wire logic [VALUE_WIDTH-1:0]           queue_mag,
   output logic                                  queue_pop,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [ira_pkg::CHAR_W-1:0]            rsp_char_code,
   output logic                                  rsp_is_last
);

   localparam int STEP       = ira_pkg::STEP_BITS;
   localparam int NUM_CHUNKS = (VALUE_WIDTH + STEP - 1) / STEP;
   localparam int PW         = NUM_CHUNKS * STEP;
   localparam int CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
   localparam int DW         = ira_pkg::DIGIT_W;
   localparam int RW         = ira_pkg::RADIX_W;
   localparam int STACK_W    = VALUE_WIDTH * DW;
   localparam int DEPTH_W    = $clog2(VALUE_WIDTH + 1);

   ira_pkg::ira_state_type state_ff, state_in;

   logic [PW-1:0]              work_ff, work_in;
   logic [RW-1:0]              rem_ff, rem_in;
   logic [CHUNK_W-1:0]         chunk_ff, chunk_in;
   logic [RW-1:0]              radix_ff, radix_in;
   logic                       pow2_ff, pow2_in;
   logic [2:0]                 shift_ff, shift_in;
   logic                       minus_ff, minus_in;
   logic [STACK_W-1:0]         stack_ff, stack_in;
   logic [DEPTH_W-1:0]         depth_ff, depth_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ira_pkg::CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [STEP-1:0]    step_qbits;
   logic [RW-1:0]      step_rem;
   logic [PW-1:0]      step_work;
   logic [PW+STEP-1:0] step_cat;
   logic [RW-1:0]      radix_m1;
   logic [PW-1:0]      quot;
   logic [DW-1:0]      digit;
   logic               digit_done;
   logic               out_free;
   logic               load, div_active, emit_fire;

   // Eight restoring steps of long division by the radix; the partial remainder
   // stays below the radix, so four bits of it carry over into the next step.
   always_comb begin
      logic [RW-1:0] r;
      r = rem_ff;
      for (int i = 0; i < STEP; i++) begin
         r = {r[DW-1:0], work_ff[PW-1-i]};
         if (r >= radix_ff) begin
            r = r - radix_ff;
            step_qbits[STEP-1-i] = 1'b1;
         end else begin
            step_qbits[STEP-1-i] = 1'b0;
         end
      end
      step_rem = r;
   end

   assign step_cat  = {work_ff, step_qbits};
   assign step_work = step_cat[PW-1:0];
   assign radix_m1  = radix_ff - RW'(1);

   // A power-of-two radix yields a whole digit by mask and shift, without the divider steps.
   assign quot       = pow2_ff ? (work_ff >> shift_ff) : step_work;
   assign digit      = pow2_ff ? (work_ff[DW-1:0] & radix_m1[DW-1:0]) : step_rem[DW-1:0];
   assign digit_done = pow2_ff || (chunk_ff == CHUNK_W'(NUM_CHUNKS - 1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ira_pkg::ST_IDLE: begin
            if (!queue_empty) begin
               state_in = ira_pkg::ST_DIVIDE;
            end
         end
         ira_pkg::ST_DIVIDE: begin
            if (digit_done && (quot == '0)) begin
               state_in = ira_pkg::ST_EMIT;
            end
         end
         ira_pkg::ST_EMIT: begin
            if (out_free && !minus_ff && (depth_ff == DEPTH_W'(1))) begin
               state_in = ira_pkg::ST_IDLE;
            end
         end
         default: state_in = ira_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      load       = 1'b0;
      div_active = 1'b0;
      emit_fire  = 1'b0;
      unique case (state_ff)
         ira_pkg::ST_IDLE:   load       = !queue_empty;
         ira_pkg::ST_DIVIDE: div_active = 1'b1;
         ira_pkg::ST_EMIT:   emit_fire  = out_free;
         default: ;
      endcase
   end

   assign queue_pop = load;

   always_comb begin
      work_in      = work_ff;
      rem_in       = rem_ff;
      chunk_in     = chunk_ff;
      radix_in     = radix_ff;
      pow2_in      = pow2_ff;
      shift_in     = shift_ff;
      minus_in     = minus_ff;
      stack_in     = stack_ff;
      depth_in     = depth_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      if (load) begin
         work_in  = PW'(queue_mag);
         rem_in   = '0;
         chunk_in = '0;
         radix_in = queue_class.radix;
         pow2_in  = queue_class.pow2;
         shift_in = queue_class.shift;
         minus_in = queue_class.neg;
         depth_in = '0;
      end

      if (div_active) begin
         if (digit_done) begin
            stack_in = {stack_ff[STACK_W-DW-1:0], digit};
            depth_in = depth_ff + DEPTH_W'(1);
            work_in  = quot;
            rem_in   = '0;
            chunk_in = '0;
         end else begin
            work_in  = step_work;
            rem_in   = step_rem;
            chunk_in = chunk_ff + CHUNK_W'(1);
         end
      end

      if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      // The sign goes out first, then the digits from the top of the stack.
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         if (minus_ff) begin
            rsp_char_in = ira_pkg::CHAR_MINUS;
            rsp_last_in = 1'b0;
            minus_in    = 1'b0;
         end else begin
            rsp_char_in = ira_pkg::digit_char(stack_ff[DW-1:0]);
            rsp_last_in = (depth_ff == DEPTH_W'(1));
            stack_in    = {{DW{1'b0}}, stack_ff[STACK_W-1:DW]};
            depth_in    = depth_ff - DEPTH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ira_pkg::ST_IDLE;
         minus_ff     <= 1'b0;
         depth_ff     <= '0;
         chunk_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         minus_ff     <= minus_in;
         depth_ff     <= depth_in;
         chunk_ff     <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      rem_ff      <= rem_in;
      radix_ff    <= radix_in;
      pow2_ff     <= pow2_in;
      shift_ff    <= shift_in;
      stack_ff    <= stack_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_is_last   = rsp_last_ff;

endmodule

`default_nettype wire

// File: design/integer_to_radix_ascii_core.sv
// Top level of the integer to radix ASCII converter with its configuration register.
`timescale 1ns / 1ps
`default_nettype none

// Converts each signed two's complement integer on the req_ channel into its text in the
// radix held by the radix register (byte address 0; values below 2 act as 2, above 16 as
// 16), most significant character first on the rsp_ channel, one character per beat. A
// negative value starts with '-', zero gives "0", digits ten to fifteen are 'A' to 'F',
// and rsp_is_last marks the final character. A front end classifies each value and
// places it in a two-entry queue, so input beats keep being taken while the engine
// works, until the queue is full. The engine loads an item from the queue and then
// forms one digit at a time, by mask and shift for radix 2, 4, 8 or 16 and otherwise
// with its divider (which handles eight dividend bits a cycle); it then sends the
// characters out one at a time, holding while rsp_stall is set, and takes the next
// item only after the last character of the current one has been issued.
// The radix must be written only while the block is idle.
module integer_to_radix_ascii_core #(
   parameter int VALUE_WIDTH = ira_pkg::DEFAULT_VALUE_WIDTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [VALUE_WIDTH-1:0]       req_value,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [ira_pkg::CHAR_W-1:0]               rsp_char_code,
   output logic                                     rsp_is_last,

   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [ira_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [ira_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [ira_pkg::CSR_DATA_W-1:0]           prdata,
   output logic                                     pready
);

   localparam int CLASS_W = $bits(ira_pkg::ira_class_type);
   localparam int ENTRY_W = CLASS_W + VALUE_WIDTH;

   logic [ira_pkg::RADIX_W-1:0] radix_ff, radix_in;
   logic                        csr_write;
   logic                        radix_sel;

   logic                   push, queue_full, queue_empty, queue_pop;
   ira_pkg::ira_class_type push_class, pop_class;
   logic [VALUE_WIDTH-1:0] push_mag, pop_mag;
   logic [ENTRY_W-1:0]     push_data, pop_data;

   assign pready    = 1'b1;
   assign radix_sel = (paddr[ira_pkg::CSR_ADDR_W-1] == ira_pkg::CSR_RADIX_WORD);
   assign csr_write = psel && penable && pwrite && pready && radix_sel;
   assign radix_in  = csr_write ? pwdata[ira_pkg::RADIX_W-1:0] : radix_ff;
   assign prdata    = radix_sel ? ira_pkg::CSR_DATA_W'(radix_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= ira_pkg::RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   ira_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .req_valid  (req_valid),
      .req_value  (req_value),
      .req_stall  (req_stall),
      .radix      (radix_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_class (push_class),
      .push_mag   (push_mag)
   );

   assign push_data = {push_class, push_mag};
   assign pop_class = pop_data[ENTRY_W-1:VALUE_WIDTH];
   assign pop_mag   = pop_data[VALUE_WIDTH-1:0];

   ira_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   ira_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .queue_class   (pop_class),
      .queue_mag     (pop_mag),
      .queue_pop     (queue_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_is_last   (rsp_is_last)
   );

endmodule

`default_nettype wire
